@@ sv/adaptive_batch_size_regulator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive batch size regulator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BATCH_SIZE_REGULATOR_MACROS_SVH
`define ADAPTIVE_BATCH_SIZE_REGULATOR_MACROS_SVH

// Same-cycle implication.
`define ABR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abr assertion failed");

// Next-cycle implication.
`define ABR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abr assertion failed");

`endif

@@ sv/abr_pkg.sv @@
// ----------------------------------------------------------------------------
// abr_pkg
// Shared codes, register reset values and types of the batch size regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package abr_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATCH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UTIL_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UTIL_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATENCY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WAIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_FACTOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_MIN_BATCH     = 16'd1;
    localparam logic [15:0] RST_MAX_BATCH     = 16'd512;
    localparam logic [6:0]  RST_UTIL_LOW      = 7'd60;
    localparam logic [6:0]  RST_UTIL_HIGH     = 7'd90;
    localparam logic [23:0] RST_MAX_LATENCY   = 24'd10000;
    localparam logic [23:0] RST_TARGET_WAIT   = 24'd1000;
    localparam logic [9:0]  RST_GROW_FACTOR   = 10'd384;
    localparam logic [8:0]  RST_SHRINK_FACTOR = 9'd192;

    // Parameter defaults.
    localparam int HISTORY_DEPTH_DEF  = 64;
    localparam int MIN_SAMPLES_DEF    = 8;
    localparam int MAX_RUN_DEF        = 5;
    localparam int COOLDOWN_TICKS_DEF = 5;
    localparam int INIT_SIZE_DEF      = 64;

    // Largest value the window fill output field can show.
    localparam logic [6:0] FILL_OUT_MAX = 7'd127;

    typedef struct packed {
        logic [15:0] min_batch;
        logic [15:0] max_batch;
        logic [6:0]  util_low;
        logic [6:0]  util_high;
        logic [23:0] max_latency;
        logic [23:0] target_wait;
        logic [9:0]  grow_factor;
        logic [8:0]  shrink_factor;
    } t_cfg;

    typedef struct packed {
        logic [15:0] cur_size;
        logic        changed;
        logic        grew;
        logic [31:0] adapt_count;
    } t_ctrl_res;

    typedef struct packed {
        logic [15:0] cur_size;
        logic        changed;
        logic        grew;
        logic [31:0] adapt_count;
        logic [6:0]  window_fill;
    } t_result;

endpackage

`default_nettype wire

@@ sv/abr_ram.sv @@
// ----------------------------------------------------------------------------
// abr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module abr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/abr_cfg.sv @@
// ----------------------------------------------------------------------------
// abr_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module abr_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [abr_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [abr_pkg::CFG_DATA_W-1:0]  i_data,
    output abr_pkg::t_cfg                        o_cfg
);

    abr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_batch     <= abr_pkg::RST_MIN_BATCH;
            r_cfg.max_batch     <= abr_pkg::RST_MAX_BATCH;
            r_cfg.util_low      <= abr_pkg::RST_UTIL_LOW;
            r_cfg.util_high     <= abr_pkg::RST_UTIL_HIGH;
            r_cfg.max_latency   <= abr_pkg::RST_MAX_LATENCY;
            r_cfg.target_wait   <= abr_pkg::RST_TARGET_WAIT;
            r_cfg.grow_factor   <= abr_pkg::RST_GROW_FACTOR;
            r_cfg.shrink_factor <= abr_pkg::RST_SHRINK_FACTOR;
        end else if (i_we) begin
            case (i_index)
                abr_pkg::CFG_MIN_BATCH:     r_cfg.min_batch     <= i_data[15:0];
                abr_pkg::CFG_MAX_BATCH:     r_cfg.max_batch     <= i_data[15:0];
                abr_pkg::CFG_UTIL_LOW:      r_cfg.util_low      <= i_data[6:0];
                abr_pkg::CFG_UTIL_HIGH:     r_cfg.util_high     <= i_data[6:0];
                abr_pkg::CFG_MAX_LATENCY:   r_cfg.max_latency   <= i_data[23:0];
                abr_pkg::CFG_TARGET_WAIT:   r_cfg.target_wait   <= i_data[23:0];
                abr_pkg::CFG_GROW_FACTOR:   r_cfg.grow_factor   <= i_data[9:0];
                abr_pkg::CFG_SHRINK_FACTOR: r_cfg.shrink_factor <= i_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/abr_window.sv @@
// ----------------------------------------------------------------------------
// abr_window
// Sliding window of batch metrics kept in a ring RAM with running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module abr_window #(
    parameter int HISTORY_DEPTH = abr_pkg::HISTORY_DEPTH_DEF,
    parameter int FW  = $clog2(HISTORY_DEPTH + 1),
    parameter int USW = 7 + $clog2(HISTORY_DEPTH),
    parameter int TSW = 24 + $clog2(HISTORY_DEPTH)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_rec,
    input  wire logic [6:0]     i_util,
    input  wire logic [23:0]    i_infer,
    input  wire logic [23:0]    i_wait,
    output logic      [USW-1:0] o_util_sum,
    output logic      [TSW-1:0] o_infer_sum,
    output logic      [TSW-1:0] o_wait_sum,
    output logic      [FW-1:0]  o_fill,
    output logic      [FW-1:0]  o_fill_nx
);

    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int EW = 7 + 24 + 24;

    logic [PW-1:0]  r_wptr,  n_wptr;
    logic [FW-1:0]  r_fill,  n_fill;
    logic [USW-1:0] r_usum,  n_usum;
    logic [TSW-1:0] r_isum,  n_isum;
    logic [TSW-1:0] r_wsum,  n_wsum;
    logic           r_byp;
    logic [EW-1:0]  r_byp_data;
    logic [EW-1:0]  w_wdata;
    logic [EW-1:0]  w_ram_q;
    logic [EW-1:0]  w_old;
    logic           w_full;

    assign w_wdata = {i_util, i_infer, i_wait};
    assign w_full  = (r_fill == FW'(HISTORY_DEPTH));

    // The RAM is always read at the slot the next record will overwrite, so the
    // oldest entry is ready when that record arrives.
    abr_ram #(
        .WIDTH (EW),
        .DEPTH (HISTORY_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_rec),
        .i_waddr (r_wptr),
        .i_wdata (w_wdata),
        .i_raddr (n_wptr),
        .o_rdata (w_ram_q)
    );

    // A write to the slot being read in the same cycle only happens with a
    // single-entry window; the written word is forwarded then.
    assign w_old = r_byp ? r_byp_data : w_ram_q;

    always_comb begin
        n_wptr = r_wptr;
        n_fill = r_fill;
        n_usum = r_usum;
        n_isum = r_isum;
        n_wsum = r_wsum;
        if (i_rec) begin
            n_wptr = (r_wptr == PW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            if (w_full) begin
                n_usum = r_usum + USW'(i_util)  - USW'(w_old[54:48]);
                n_isum = r_isum + TSW'(i_infer) - TSW'(w_old[47:24]);
                n_wsum = r_wsum + TSW'(i_wait)  - TSW'(w_old[23:0]);
            end else begin
                n_fill = r_fill + FW'(1);
                n_usum = r_usum + USW'(i_util);
                n_isum = r_isum + TSW'(i_infer);
                n_wsum = r_wsum + TSW'(i_wait);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_fill <= '0;
            r_usum <= '0;
            r_isum <= '0;
            r_wsum <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_wptr <= n_wptr;
            r_fill <= n_fill;
            r_usum <= n_usum;
            r_isum <= n_isum;
            r_wsum <= n_wsum;
            r_byp  <= i_rec && (r_wptr == n_wptr);
        end
        r_byp_data <= w_wdata;
    end

    assign o_util_sum  = r_usum;
    assign o_infer_sum = r_isum;
    assign o_wait_sum  = r_wsum;
    assign o_fill      = r_fill;
    assign o_fill_nx   = n_fill;

endmodule

`default_nettype wire

@@ sv/abr_ctrl.sv @@
// ----------------------------------------------------------------------------
// abr_ctrl
// Batch size decision: cooldown, run limit, grow or shrink with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module abr_ctrl #(
    parameter int HISTORY_DEPTH  = abr_pkg::HISTORY_DEPTH_DEF,
    parameter int MIN_SAMPLES    = abr_pkg::MIN_SAMPLES_DEF,
    parameter int MAX_RUN        = abr_pkg::MAX_RUN_DEF,
    parameter int COOLDOWN_TICKS = abr_pkg::COOLDOWN_TICKS_DEF,
    parameter int INIT_SIZE      = abr_pkg::INIT_SIZE_DEF,
    parameter int FW  = $clog2(HISTORY_DEPTH + 1),
    parameter int USW = 7 + $clog2(HISTORY_DEPTH),
    parameter int TSW = 24 + $clog2(HISTORY_DEPTH)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [1:0]     i_op,
    input  wire abr_pkg::t_cfg  i_cfg,
    input  wire logic [USW-1:0] i_util_sum,
    input  wire logic [TSW-1:0] i_infer_sum,
    input  wire logic [TSW-1:0] i_wait_sum,
    input  wire logic [FW-1:0]  i_fill,
    output abr_pkg::t_ctrl_res  o_res
);

    localparam int UPW = 7 + FW;
    localparam int LPW = 25 + FW;
    localparam int WPW = 26 + FW;

    logic [15:0] r_size,  n_size;
    logic [7:0]  r_ticks, n_ticks;
    logic [7:0]  r_run,   n_run;
    logic [31:0] r_total, n_total;
    logic        r_grew,  n_grew;
    logic        n_changed;

    logic [UPW-1:0] w_ulo, w_uhi;
    logic [LPW-1:0] w_lat, w_lat1;
    logic [WPW-1:0] w_wt,  w_wt2;
    logic           w_grow_c, w_shrink_c, w_ready;
    logic [25:0]    w_gprod;
    logic [24:0]    w_sprod;
    logic [17:0]    w_gsz;
    logic [16:0]    w_ssz, w_smax;
    logic [15:0]    w_gcl, w_scl, w_cand;
    logic           w_decided;

    // Averages are compared as sum against bound times sample count.
    assign w_ulo  = UPW'(i_cfg.util_low)  * UPW'(i_fill);
    assign w_uhi  = UPW'(i_cfg.util_high) * UPW'(i_fill);
    assign w_lat  = LPW'(i_cfg.max_latency) * LPW'(i_fill);
    assign w_lat1 = (LPW'(i_cfg.max_latency) + LPW'(1)) * LPW'(i_fill);
    assign w_wt   = WPW'(i_cfg.target_wait) * WPW'(i_fill);
    assign w_wt2  = WPW'({i_cfg.target_wait, 1'b1}) * WPW'(i_fill);

    assign w_grow_c = (UPW'(i_util_sum) < w_ulo) && (LPW'(i_infer_sum) < w_lat)
                    && (WPW'(i_wait_sum) < w_wt);
    assign w_shrink_c = (LPW'(i_infer_sum) >= w_lat1) || (WPW'(i_wait_sum) >= w_wt2)
                      || (UPW'(i_util_sum) > w_uhi);

    assign w_gprod = 26'(r_size) * 26'(i_cfg.grow_factor);
    assign w_gsz   = w_gprod[25:8];
    assign w_gcl   = (w_gsz > 18'(i_cfg.max_batch)) ? i_cfg.max_batch : w_gsz[15:0];

    assign w_sprod = 25'(r_size) * 25'(i_cfg.shrink_factor);
    assign w_ssz   = w_sprod[24:8];
    assign w_smax  = (w_ssz < 17'(i_cfg.min_batch)) ? 17'(i_cfg.min_batch) : w_ssz;
    assign w_scl   = w_smax[16] ? 16'hFFFF : w_smax[15:0];

    assign w_ready = (32'(i_fill) >= MIN_SAMPLES) && (r_ticks >= 8'(COOLDOWN_TICKS));

    always_comb begin
        n_size    = r_size;
        n_ticks   = r_ticks;
        n_run     = r_run;
        n_total   = r_total;
        n_grew    = r_grew;
        n_changed = 1'b0;
        w_decided = 1'b0;
        w_cand    = r_size;
        if (i_step) begin
            case (i_op)
                abr_pkg::OP_ADJUST: begin
                    if (w_ready) begin
                        if (r_run >= 8'(MAX_RUN)) begin
                            // A full run of changes just ends the run.
                            n_run = '0;
                        end else begin
                            if (w_grow_c) begin
                                w_decided = 1'b1;
                                w_cand    = w_gcl;
                                n_grew    = 1'b1;
                            end else if (w_shrink_c) begin
                                w_decided = 1'b1;
                                w_cand    = w_scl;
                                n_grew    = 1'b0;
                            end
                            if (w_decided && (w_cand != r_size)) begin
                                n_size    = w_cand;
                                n_ticks   = '0;
                                n_run     = r_run + 8'd1;
                                n_total   = r_total + 32'd1;
                                n_changed = 1'b1;
                            end
                        end
                    end
                end
                abr_pkg::OP_TICK: begin
                    if (r_ticks != 8'hFF) begin
                        n_ticks = r_ticks + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 16'(INIT_SIZE);
            r_ticks <= '0;
            r_run   <= '0;
            r_total <= '0;
            r_grew  <= 1'b0;
        end else begin
            r_size  <= n_size;
            r_ticks <= n_ticks;
            r_run   <= n_run;
            r_total <= n_total;
            r_grew  <= n_grew;
        end
    end

    assign o_res.cur_size    = n_size;
    assign o_res.changed     = n_changed;
    assign o_res.grew        = n_grew;
    assign o_res.adapt_count = n_total;

endmodule

`default_nettype wire

@@ sv/adaptive_batch_size_regulator.sv @@
// ----------------------------------------------------------------------------
// adaptive_batch_size_regulator
// Tracks a window of batch metrics and grows or shrinks the batch size.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   op, util, infer time, wait time
//  out       from block o_out_valid / i_out_stall batch size, flags, counts, fill
//  cfg       to block   i_cfg_valid / o_cfg_ready register index, write data
//
//  One item per cycle sustained while the output is not stalled; a taken item
//  moves through the input register, then the result register.
//  The window RAM is read ahead at the next write slot, which keeps
//  back-to-back records at full rate.
//  Reset is synchronous and needs no clearing pass; window slots are only
//  used after they are written. A stalled output holds its result while the
//  input register still takes one more item.
`default_nettype none

`include "adaptive_batch_size_regulator_macros.svh"

module adaptive_batch_size_regulator #(
    parameter int HISTORY_DEPTH  = abr_pkg::HISTORY_DEPTH_DEF,
    parameter int MIN_SAMPLES    = abr_pkg::MIN_SAMPLES_DEF,
    parameter int MAX_RUN        = abr_pkg::MAX_RUN_DEF,
    parameter int COOLDOWN_TICKS = abr_pkg::COOLDOWN_TICKS_DEF,
    parameter int INIT_SIZE      = abr_pkg::INIT_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_op,
    input  wire logic [6:0]                     i_util_percent,
    input  wire logic [23:0]                    i_infer_time_us,
    input  wire logic [23:0]                    i_wait_time_us,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [15:0]                    o_batch_size,
    output logic                                o_changed,
    output logic                                o_grew,
    output logic      [31:0]                    o_adapt_count,
    output logic      [6:0]                     o_window_fill,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [abr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [abr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FW  = $clog2(HISTORY_DEPTH + 1);
    localparam int USW = 7 + $clog2(HISTORY_DEPTH);
    localparam int TSW = 24 + $clog2(HISTORY_DEPTH);
    localparam int FILL_LIM = (HISTORY_DEPTH < 127) ? HISTORY_DEPTH : 127;

    abr_pkg::t_cfg     w_cfg;
    abr_pkg::t_ctrl_res w_ctrl;
    abr_pkg::t_result  r_res, n_res;

    logic        r_iv;
    logic [1:0]  r_in_op;
    logic [6:0]  r_in_util;
    logic [23:0] r_in_infer;
    logic [23:0] r_in_wait;
    logic        r_ov;
    logic        w_advance;
    logic        w_accept;
    logic        w_rec;

    logic [USW-1:0] w_usum;
    logic [TSW-1:0] w_isum, w_wsum;
    logic [FW-1:0]  w_fill, w_fill_nx;

    // The item in the input register moves on whenever the result register is
    // empty or is being emptied.
    assign w_advance  = r_iv && (!r_ov || !i_out_stall);
    assign o_in_stall = r_iv && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_rec      = w_advance && (r_in_op == abr_pkg::OP_RECORD);

    assign o_cfg_ready = 1'b1;

    abr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    abr_window #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FW            (FW),
        .USW           (USW),
        .TSW           (TSW)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (w_rec),
        .i_util      (r_in_util),
        .i_infer     (r_in_infer),
        .i_wait      (r_in_wait),
        .o_util_sum  (w_usum),
        .o_infer_sum (w_isum),
        .o_wait_sum  (w_wsum),
        .o_fill      (w_fill),
        .o_fill_nx   (w_fill_nx)
    );

    abr_ctrl #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .MIN_SAMPLES    (MIN_SAMPLES),
        .MAX_RUN        (MAX_RUN),
        .COOLDOWN_TICKS (COOLDOWN_TICKS),
        .INIT_SIZE      (INIT_SIZE),
        .FW             (FW),
        .USW            (USW),
        .TSW            (TSW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_op        (r_in_op),
        .i_cfg       (w_cfg),
        .i_util_sum  (w_usum),
        .i_infer_sum (w_isum),
        .i_wait_sum  (w_wsum),
        .i_fill      (w_fill),
        .o_res       (w_ctrl)
    );

    always_comb begin
        n_res.cur_size    = w_ctrl.cur_size;
        n_res.changed     = w_ctrl.changed;
        n_res.grew        = w_ctrl.grew;
        n_res.adapt_count = w_ctrl.adapt_count;
        n_res.window_fill = (32'(w_fill_nx) > 32'(abr_pkg::FILL_OUT_MAX))
                          ? abr_pkg::FILL_OUT_MAX : 7'(w_fill_nx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv  <= 1'b0;
            r_ov  <= 1'b0;
            r_res <= '0;
        end else begin
            if (w_accept) begin
                r_iv <= 1'b1;
            end else if (w_advance) begin
                r_iv <= 1'b0;
            end
            if (w_advance) begin
                r_ov  <= 1'b1;
                r_res <= n_res;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (w_accept) begin
            r_in_op    <= i_op;
            r_in_util  <= i_util_percent;
            r_in_infer <= i_infer_time_us;
            r_in_wait  <= i_wait_time_us;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_batch_size  = r_res.cur_size;
    assign o_changed     = r_res.changed;
    assign o_grew        = r_res.grew;
    assign o_adapt_count = r_res.adapt_count;
    assign o_window_fill = r_res.window_fill;

    // The input side only stalls while a result is held back downstream.
    `ABR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_iv && r_ov && i_out_stall)
    // Every item that leaves the input register shows up as a result.
    `ABR_ASSERT_NEXT(a_advance_out, i_clk, i_rst_n, w_advance, o_out_valid)
    // Only an adjust request may report a change.
    `ABR_ASSERT_NEXT(a_change_op, i_clk, i_rst_n,
        w_advance && (r_in_op != abr_pkg::OP_ADJUST), !o_changed)
    // A reported change bumps the change total by exactly one.
    `ABR_ASSERT_NEXT(a_change_count, i_clk, i_rst_n, w_advance && n_res.changed,
        o_adapt_count == $past(r_res.adapt_count) + 32'd1)
    // The window never reports more samples than it can hold.
    `ABR_ASSERT_NOW(a_fill_limit, i_clk, i_rst_n, o_out_valid, 32'(o_window_fill) <= FILL_LIM)

endmodule

`default_nettype wire
